>>> rtl/core/shamh_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and round functions for the sha-256 message hasher
// no dependencies
package shamh_pkg;

	localparam int LenBitsDefault = 32;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);

	typedef struct packed {
		logic [31:0] data;
		logic        final_blk;
	} q_entry_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		case (idx)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		case (r)
			6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

>>> rtl/core/shamh_front.sv
`timescale 1ns / 1ps
// front end: packs bytes into words, counts length, generates padding words
// depends on shamh_pkg
module shamh_front #(
	parameter int LENGTH_BITS = shamh_pkg::LenBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               byte_present,
	input  logic               last_byte,
	output logic               push,
	output shamh_pkg::q_entry_t push_entry,
	input  logic               q_ready
);
	import shamh_pkg::*;

	logic [31:0]            word_q;
	logic [5:0]             pos_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic                   pad_q;
	logic                   first_q;
	logic                   extra_q;
	logic [3:0]             pidx_q;

	logic        acc;
	logic [31:0] nword;
	logic [5:0]  npos;
	logic [5:0]  peff;
	logic [63:0] bits;
	logic [31:0] pad_word;
	logic        pad_final;

	assign in_ready = !pad_q && q_ready;
	assign acc      = in_valid && in_ready;
	assign nword    = {word_q[23:0], data_byte};
	assign npos     = pos_q + 6'd1;
	assign peff     = byte_present ? npos : pos_q;
	assign bits     = 64'({len_q, 3'b000});
	assign pad_final = !extra_q && (pidx_q == 4'd15);

	always_comb begin
		if (first_q) begin
			case (pos_q[1:0])
				2'd0: pad_word = 32'h80000000;
				2'd1: pad_word = {word_q[7:0], 8'h80, 16'h0000};
				2'd2: pad_word = {word_q[15:0], 8'h80, 8'h00};
				default: pad_word = {word_q[23:0], 8'h80};
			endcase
		end else if (!extra_q && pidx_q == 4'd14) begin
			pad_word = bits[63:32];
		end else if (pad_final) begin
			pad_word = bits[31:0];
		end else begin
			pad_word = 32'h0;
		end
	end

	always_comb begin
		push_entry.data      = nword;
		push_entry.final_blk = 1'b0;
		push                 = 1'b0;
		if (pad_q) begin
			push                 = 1'b1;
			push_entry.data      = pad_word;
			push_entry.final_blk = pad_final && !first_q;
		end else if (acc && byte_present && pos_q[1:0] == 2'd3) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			extra_q <= 1'b0;
			pidx_q  <= '0;
		end else if (pad_q) begin
			if (q_ready) begin
				first_q <= 1'b0;
				if (pad_final && !first_q) begin
					pad_q <= 1'b0;
					pos_q <= '0;
					len_q <= '0;
				end else begin
					pidx_q <= pidx_q + 4'd1;
					if (pidx_q == 4'd15)
						extra_q <= 1'b0;
				end
			end
		end else if (acc) begin
			if (byte_present) begin
				pos_q <= npos;
				len_q <= len_q + LENGTH_BITS'(1);
			end
			if (last_byte) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
				pidx_q  <= peff[5:2];
				extra_q <= (peff > 6'd55);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && byte_present)
			word_q <= nword;
	end

endmodule

>>> rtl/core/shamh_fifo.sv
`timescale 1ns / 1ps
// short word queue between the front end and the compression engine
// depends on shamh_pkg
module shamh_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  shamh_pkg::q_entry_t push_entry,
	output logic                q_ready,
	output logic                pop_valid,
	output shamh_pkg::q_entry_t pop_entry,
	input  logic                pop
);
	import shamh_pkg::*;

	q_entry_t               mem_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_q;
	logic [QueuePtrW-1:0]   rd_q;
	logic [QueuePtrW:0]     cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign q_ready   = (cnt_q != QueueDepth[QueuePtrW:0]);
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = mem_q[rd_q];
	assign do_push   = push && q_ready;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QueuePtrW'(1);
			if (do_pop)
				rd_q <= rd_q + QueuePtrW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (QueuePtrW + 1)'(1);
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - (QueuePtrW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

endmodule

>>> rtl/core/shamh_back.sv
`timescale 1ns / 1ps
// back end: message schedule, 64-round compression and digest output
// depends on shamh_pkg
module shamh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  shamh_pkg::q_entry_t pop_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_index,
	output logic                final_word
);
	import shamh_pkg::*;

	typedef enum logic [1:0] {LOAD, ROUND, ADDH, EMIT} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [3:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        final_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] wnew;
	logic [31:0] shift_in;

	assign pop         = (state_q == LOAD) && pop_valid;
	assign out_valid   = (state_q == EMIT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign final_word  = (oidx_q == 3'd7);

	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(rnd_q) + w_q[0];
	assign t2 = big_sig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign wnew = sml_sig1(w_q[14]) + w_q[9] + sml_sig0(w_q[1]) + w_q[0];
	assign shift_in = (state_q == LOAD) ? pop_entry.data : wnew;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			cnt_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			final_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= init_hash(3'(i));
		end else begin
			unique case (state_q)
				LOAD: begin
					if (pop_valid) begin
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd15) begin
							final_q <= pop_entry.final_blk;
							rnd_q   <= '0;
							state_q <= ROUND;
						end
					end
				end
				ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ADDH;
				end
				ADDH: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
					oidx_q  <= '0;
					state_q <= final_q ? EMIT : LOAD;
				end
				EMIT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								h_q[i] <= init_hash(3'(i));
							state_q <= LOAD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	// schedule shift line and working variables
	always_ff @(posedge clk) begin
		if (pop || state_q == ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= shift_in;
		end
		if (pop && cnt_q == 4'd15) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (state_q == ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

>>> rtl/core/sha256_message_hasher.sv
`timescale 1ns / 1ps
// top level of the sha-256 message hasher: front end, word queue, compression engine
// depends on shamh_pkg, shamh_front, shamh_fifo, shamh_back
//
// input channel: one message byte per transfer (data_byte with byte_present),
// last_byte ends the message; byte_present low with last_byte high is an empty
// end marker, and both low is an idle transfer
// output channel: eight digest words per message, word_index 0 first, final_word
// on word 7
// the front end takes one byte per cycle while the four-entry queue has room and
// no padding is pending, and pushes a word every fourth byte; the engine loads 16
// words, runs 64 rounds at one per cycle and then folds into the hash in its ADDH
// state; the queue holds only 16 bytes, so under a steady stream the block rate
// is set by the front end refilling the queue while the engine loads
// at message end the front end issues padding and length words one per cycle
// while the queue has room (one or two blocks)
// a stalled receiver holds the engine in output; the front end keeps taking
// bytes until the queue fills
// reset returns to the initial hash values with an empty message
module sha256_message_hasher #(
	parameter int LENGTH_BITS = shamh_pkg::LenBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);
	import shamh_pkg::*;

	logic     push;
	q_entry_t push_entry;
	logic     q_ready;
	logic     pop_valid;
	q_entry_t pop_entry;
	logic     pop;

	shamh_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .byte_present, .last_byte,
		.push, .push_entry, .q_ready
	);

	shamh_fifo u_fifo (
		.clk, .arst_n, .push, .push_entry, .q_ready, .pop_valid, .pop_entry, .pop
	);

	shamh_back u_back (
		.clk, .arst_n, .pop_valid, .pop_entry, .pop, .out_valid, .out_ready,
		.digest_word, .word_index, .final_word
	);

	a_in_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> q_ready)
		else $error("input taken with full queue");

	a_no_pop_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !pop)
		else $error("queue popped during digest output");

	a_idle_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_word |=> !out_valid)
		else $error("output still valid after final digest word");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for sha256_message_hasher: byte stream in, digest words out
// depends on the hasher rtl; holds its own sha-256 predictor
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        byte_present = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} byte_xfer_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_xfer_t;

	localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// predictor state
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [5:0]  fill;
	logic [31:0] msg_len;

	byte_xfer_t   pending_bytes [$];
	digest_xfer_t digest_queue [$];
	bit           failed = 1'b0;
	bit           feeding_done = 1'b0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           hold_left = 0;
	int           stall_cycles = 0;

	sha256_message_hasher uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .byte_present(byte_present), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .final_word(final_word)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_blk();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2, x, y;
		for (int k = 0; k < 16; k++) w[k] = blk[k];
		for (int k = 0; k < 8; k++) v[k] = chain[k];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				x = w[(r - 15) & 15];
				y = w[(r - 2) & 15];
				wt = (ror(y, 17) ^ ror(y, 19) ^ (y >> 10)) + w[(r - 7) & 15]
					+ (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[r & 15];
				w[r & 15] = wt;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wt;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++) chain[k] = chain[k] + v[k];
	endfunction

	function automatic void hash_reset();
		for (int k = 0; k < 8; k++) chain[k] = IV[k];
		for (int k = 0; k < 16; k++) blk[k] = '0;
		fill = '0;
		msg_len = '0;
	endfunction

	function automatic void hash_byte(byte_xfer_t t);
		int wi, sh;
		logic [63:0] bits;
		logic [31:0] keep;
		if (t.present) begin
			sh = 24 - 8 * fill[1:0];
			wi = int'(fill[5:2]);
			blk[wi] = (blk[wi] & ~(32'hff << sh)) | (32'(t.data) << sh);
			msg_len = msg_len + 32'd1;
			fill = fill + 6'd1;
			if (fill == 0) compress_blk();
		end
		if (!t.last) return;
		wi = int'(fill[5:2]);
		keep = (fill[1:0] == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * fill[1:0]));
		blk[wi] = (blk[wi] & keep) | (32'h80 << (24 - 8 * fill[1:0]));
		for (int k = wi + 1; k < 16; k++) blk[k] = '0;
		bits = 64'(msg_len) << 3;
		if (fill > 55) begin
			compress_blk();
			for (int k = 0; k < 16; k++) blk[k] = '0;
		end
		blk[14] = bits[63:32];
		blk[15] = bits[31:0];
		compress_blk();
		for (int k = 0; k < 8; k++)
			digest_queue.push_back('{chain[k], 3'(k), k == 7});
		for (int k = 0; k < 8; k++) chain[k] = IV[k];
		fill = '0;
		msg_len = '0;
	endfunction

	function automatic void add_msg(int len, bit empty_end, bit all_ff);
		for (int k = 0; k < len; k++)
			pending_bytes.push_back('{all_ff ? 8'hff : 8'($urandom_range(0, 255)), 1'b1,
				!empty_end && k == len - 1});
		if (empty_end || len == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				hash_byte('{data_byte, byte_present, last_byte});
				void'(pending_bytes.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() == 0 || (!in_valid && gap_left > 0)) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
				end else if (burst_left == 0) begin
					in_valid <= 1'b0;
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					in_valid <= 1'b1;
					burst_left <= burst_left - 1;
					{data_byte, byte_present, last_byte} <= pending_bytes[0];
				end
			end
		end
	end

	// receiver stall pattern and monitor
	always @(posedge clk) begin
		digest_xfer_t exp_d;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest transfer: actual %h/%0d/%0d", $time,
						digest_word, word_index, final_word);
					failed = 1'b1;
				end else begin
					exp_d = digest_queue.pop_front();
					if (exp_d.word !== digest_word)
						$display("%0t: digest_word expected %h actual %h", $time, exp_d.word,
							digest_word);
					if (exp_d.idx !== word_index)
						$display("%0t: word_index expected %0d actual %0d", $time, exp_d.idx,
							word_index);
					if (exp_d.last !== final_word)
						$display("%0t: final_word expected %0d actual %0d", $time, exp_d.last,
							final_word);
					if (exp_d !== {digest_word, word_index, final_word}) failed = 1'b1;
				end
			end
			stall_cycles <= stall_cycles + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (stall_cycles == 300 || stall_cycles == 1500) begin
				hold_left <= 600;
				out_ready <= 1'b0;
			end else if (stall_cycles % 512 < 200) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		int len;
		hash_reset();
		// directed: empty message, single bytes, padding boundaries, idles, end variants
		add_msg(0, 1'b0, 1'b0);
		pending_bytes.push_back('{8'h00, 1'b0, 1'b0});
		pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
		pending_bytes.push_back('{8'hff, 1'b1, 1'b1});
		add_msg(3, 1'b1, 1'b0);
		add_msg(55, 1'b0, 1'b1);
		add_msg(56, 1'b0, 1'b0);
		add_msg(64, 1'b0, 1'b0);
		// random short messages, with idle transfers mixed in
		while (pending_bytes.size() < 205) begin
			case ($urandom_range(0, 2))
				0: len = $urandom_range(0, 2);
				default: len = $urandom_range(1, 8);
			endcase
			if ($urandom_range(0, 3) == 0)
				pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
			add_msg(len, $urandom_range(0, 4) == 0, 1'b0);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_bytes.size() == 0 && !in_valid);
		wait (digest_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (!failed && digest_queue.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sha256_message_hasher.f
rtl/core/shamh_pkg.sv
rtl/core/shamh_front.sv
rtl/core/shamh_fifo.sv
rtl/core/shamh_back.sv
rtl/core/sha256_message_hasher.sv
verif/tb_top.sv
